// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property, checked on the rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/core/hrpd_pkg.sv =====
// Types, register codes and exponential factor tables of the hop rate pipeline.
package hrpd_pkg;

  localparam int INT_BITS = 5;

  typedef enum logic [2:0] {
    REG_BOX_X, REG_BOX_Y, REG_BOX_Z, REG_WRAP_X,
    REG_DECAY, REG_FIELD, REG_INV_KBT, REG_ATTEMPT_RATE
  } cfg_reg_t;

  // e^(-2^-j), j = 1..16, Q0.32
  localparam logic [31:0] FRAC_FACTOR [16] = '{
    32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
    32'd4162825044, 32'd4228380000, 32'd4261543595, 32'd4278222805,
    32'd4286586875, 32'd4290775039, 32'd4292870656, 32'd4293918848,
    32'd4294443040, 32'd4294705160, 32'd4294836226, 32'd4294901760
  };

  // e^(-2^k), k = 0..4, Q0.32
  localparam logic [31:0] INT_FACTOR [INT_BITS] = '{
    32'd1580030169, 32'd581260615, 32'd78665070, 32'd1440801, 32'd483
  };

  typedef struct packed {
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] dz;
    logic signed [16:0] de;
    logic signed [1:0]  q;
  } fold_t;

  typedef struct packed {
    logic [33:0]        sum;
    logic signed [33:0] e20;
  } root_in_t;

  typedef struct packed {
    logic [16:0]        root;
    logic signed [33:0] e20;
  } root_out_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [20:0] xb;
    logic        under;
    logic        up;
    logic [15:0] span;
  } exp_t;

endpackage

// ===== rtl/core/hop_rate_with_periodic_distance.sv =====
// Top level of the Miller-Abrahams hop rate pipeline with periodic distance.
// One site pair enters per clock while the pipeline is not held. Its path runs through one
// input register, 17 fold stages (16 remainder steps and a correction), square and sum
// stages, 17 square root stages, two exponent stages, one multiply stage per exp factor
// (5 + EXP_TABLE_BITS) and the output register. The whole pipeline holds while a result
// waits to be transferred, so in_ready is high when no result waits or out_ready is high.
// Registers may be written only while no item is in flight.
`include "assert_macros.svh"
module hop_rate_with_periodic_distance import hrpd_pkg::*; #(
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        src_x,
  input  logic [15:0]        src_y,
  input  logic [15:0]        src_z,
  input  logic [15:0]        dst_x,
  input  logic [15:0]        dst_y,
  input  logic [15:0]        dst_z,
  input  logic signed [15:0] energy_src,
  input  logic signed [15:0] energy_dst,
  input  logic signed [1:0]  charge,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        rate,
  output logic               uphill,
  output logic [15:0]        distance
);

  logic [15:0]        box_x, box_y, box_z, decay, inv_kbt;
  logic               wrap_x;
  logic signed [15:0] field;
  logic [31:0]        attempt_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x        <= 16'hFFFF;
      box_y        <= 16'hFFFF;
      box_z        <= 16'hFFFF;
      wrap_x       <= 1'b1;
      decay        <= 16'd256;
      field        <= '0;
      inv_kbt      <= 16'd256;
      attempt_rate <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BOX_X:        box_x        <= cfg_data[15:0];
        REG_BOX_Y:        box_y        <= cfg_data[15:0];
        REG_BOX_Z:        box_z        <= cfg_data[15:0];
        REG_WRAP_X:       wrap_x       <= cfg_data[0];
        REG_DECAY:        decay        <= cfg_data[15:0];
        REG_FIELD:        field        <= $signed(cfg_data[15:0]);
        REG_INV_KBT:      inv_kbt      <= cfg_data[15:0];
        REG_ATTEMPT_RATE: attempt_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input stage
  fold_t a_next, a_item;
  logic  a_valid;

  always_comb begin
    a_next.dx = $signed({1'b0, dst_x}) - $signed({1'b0, src_x});
    a_next.dy = $signed({1'b0, dst_y}) - $signed({1'b0, src_y});
    a_next.dz = $signed({1'b0, dst_z}) - $signed({1'b0, src_z});
    a_next.de = 17'(energy_dst) - 17'(energy_src);
    case (charge)
      2'sb01:  a_next.q = 2'sb01;
      2'sb00:  a_next.q = 2'sb00;
      default: a_next.q = 2'sb11;
    endcase
  end

  fold_t f_item;
  logic  f_valid;

  hrpd_fold u_fold (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(a_valid), .in_item(a_item),
    .box_x(box_x), .box_y(box_y), .box_z(box_z), .wrap_x(wrap_x),
    .out_valid(f_valid), .out_item(f_item)
  );

  // squares and field product
  logic               m1_valid;
  logic [31:0]        m1_sqx, m1_sqy, m1_sqz;
  logic signed [32:0] m1_fdx;
  logic signed [16:0] m1_de;
  logic signed [1:0]  m1_q;
  logic signed [33:0] px, py, pz;

  assign px = 34'($signed(f_item.dx)) * 34'($signed(f_item.dx));
  assign py = 34'($signed(f_item.dy)) * 34'($signed(f_item.dy));
  assign pz = 34'($signed(f_item.dz)) * 34'($signed(f_item.dz));

  // sum of squares and energy term
  root_in_t           m2_next, m2_item;
  logic               m2_valid;
  logic signed [33:0] qterm;

  always_comb begin
    case (m1_q)
      2'sb01:  qterm = 34'(m1_fdx);
      2'sb11:  qterm = -34'(m1_fdx);
      default: qterm = '0;
    endcase
    m2_next.sum = 34'(m1_sqx) + 34'(m1_sqy) + 34'(m1_sqz);
    m2_next.e20 = (34'(m1_de) <<< 8) + qterm;
  end

  root_out_t s_item;
  logic      s_valid;

  hrpd_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(m2_valid), .in_item(m2_item),
    .out_valid(s_valid), .out_item(s_item)
  );

  // distance and energy products
  logic [15:0] dist_sat;
  logic        p_valid, p_up;
  logic [15:0] p_dist;
  logic [31:0] p_dd;
  logic [48:0] p_ue;

  assign dist_sat = s_item.root[16] ? 16'hFFFF : s_item.root[15:0];

  // exponent
  exp_t        x_next, x_item;
  logic        x_valid;
  logic [37:0] xsum;

  always_comb begin
    xsum = {5'b0, p_dd, 1'b0} + (p_up ? {1'b0, p_ue[48:12]} : 38'd0);
    x_next.acc   = '0;
    x_next.xb    = xsum[20:0];
    x_next.under = (xsum[37:21] != '0);
    x_next.up    = p_up;
    x_next.span  = p_dist;
  end

  exp_t e_item;
  logic e_valid;

  hrpd_exp #(.FracBits(EXP_TABLE_BITS)) u_exp (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(x_valid), .in_item(x_item), .attempt_rate(attempt_rate),
    .out_valid(e_valid), .out_item(e_item)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      p_valid   <= 1'b0;
      x_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      m1_valid  <= f_valid;
      m2_valid  <= m1_valid;
      p_valid   <= s_valid;
      x_valid   <= p_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_item   <= a_next;
      m1_sqx   <= px[31:0];
      m1_sqy   <= py[31:0];
      m1_sqz   <= pz[31:0];
      m1_fdx   <= 33'(field) * 33'($signed(f_item.dx));
      m1_de    <= f_item.de;
      m1_q     <= f_item.q;
      m2_item  <= m2_next;
      p_dist   <= dist_sat;
      p_dd     <= 32'(decay) * 32'(dist_sat);
      p_up     <= (s_item.e20 > 34'sd0);
      p_ue     <= 49'(s_item.e20[32:0]) * 49'(inv_kbt);
      x_item   <= x_next;
      rate     <= e_item.under ? 32'd0 : e_item.acc;
      uphill   <= e_item.up;
      distance <= e_item.span;
    end
  end

  `ASSERT_CLK(a_flat_rate, clk, rst, out_valid && !uphill && distance == 16'd0 |-> rate == attempt_rate, "zero exponent must give the attempt rate")
  `ASSERT_CLK(a_zero_attempt, clk, rst, out_valid && attempt_rate == 32'd0 |-> rate == 32'd0, "zero attempt rate must give zero rate")
  `ASSERT_NEVER(a_rate_bound, clk, rst, out_valid && rate > attempt_rate, "rate above attempt rate")

endmodule

// ===== rtl/core/hrpd_fold.sv =====
// Pipelined periodic fold of the three displacement components.
module hrpd_fold import hrpd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  fold_t       in_item,
  input  logic [15:0] box_x,
  input  logic [15:0] box_y,
  input  logic [15:0] box_z,
  input  logic        wrap_x,
  output logic        out_valid,
  output fold_t       out_item
);

  localparam int Steps = 16;

  typedef struct packed {
    logic [15:0]        rem;
    logic [15:0]        mag;
    logic               neg;
    logic               byp;
    logic signed [16:0] d;
  } lane_t;

  function automatic lane_t div_step(lane_t s, logic [15:0] b);
    logic [16:0] t;
    lane_t r;
    r = s;
    t = {s.rem, s.mag[15]};
    r.mag = {s.mag[14:0], 1'b0};
    if (t >= {1'b0, b}) begin
      r.rem = 16'(t - {1'b0, b});
    end else begin
      r.rem = t[15:0];
    end
    return r;
  endfunction

  lane_t              st   [3][Steps];
  lane_t              init [3];
  fold_t              side [Steps];
  logic               vld  [Steps];
  logic [15:0]        box  [3];
  logic signed [16:0] din  [3];
  logic signed [16:0] res  [3];
  fold_t              o_next;

  assign box[0] = box_x;
  assign box[1] = box_y;
  assign box[2] = box_z;
  assign din[0] = in_item.dx;
  assign din[1] = in_item.dy;
  assign din[2] = in_item.dz;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      init[l].rem = '0;
      init[l].neg = din[l][16];
      init[l].mag = din[l][16] ? 16'(-din[l]) : din[l][15:0];
      init[l].byp = (box[l] == 16'd0) || ((l == 0) && !wrap_x);
      init[l].d   = din[l];
    end
  end

  always_comb begin
    logic [15:0] r;
    for (int l = 0; l < 3; l++) begin
      lane_t s;
      s = st[l][Steps-1];
      r = (s.neg && s.rem != 16'd0) ? 16'(box[l] - s.rem) : s.rem;
      if (s.byp) begin
        res[l] = s.d;
      end else if ({r, 1'b0} >= {1'b0, box[l]}) begin
        res[l] = $signed({1'b0, r}) - $signed({1'b0, box[l]});
      end else begin
        res[l] = $signed({1'b0, r});
      end
    end
  end

  always_comb begin
    o_next    = side[Steps-1];
    o_next.dx = res[0];
    o_next.dy = res[1];
    o_next.dz = res[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Steps; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Steps; k++) vld[k] <= vld[k-1];
      out_valid <= vld[Steps-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        st[l][0] <= div_step(init[l], box[l]);
        for (int k = 1; k < Steps; k++) st[l][k] <= div_step(st[l][k-1], box[l]);
      end
      side[0] <= in_item;
      for (int k = 1; k < Steps; k++) side[k] <= side[k-1];
      out_item <= o_next;
    end
  end

endmodule

// ===== rtl/core/hrpd_sqrt.sv =====
// Pipelined floor square root of the squared distance, two radicand bits a stage.
module hrpd_sqrt import hrpd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  root_in_t  in_item,
  output logic      out_valid,
  output root_out_t out_item
);

  localparam int Steps = 17;

  typedef struct packed {
    logic [18:0]        rem;
    logic [16:0]        root;
    logic [33:0]        v;
    logic signed [33:0] e20;
  } sq_t;

  function automatic sq_t sq_step(sq_t s);
    logic [20:0] t;
    logic [20:0] trial;
    sq_t r;
    r = s;
    t = {s.rem, s.v[33:32]};
    trial = {2'b00, s.root, 2'b01};
    r.v = {s.v[31:0], 2'b00};
    if (t >= trial) begin
      r.rem  = 19'(t - trial);
      r.root = {s.root[15:0], 1'b1};
    end else begin
      r.rem  = t[18:0];
      r.root = {s.root[15:0], 1'b0};
    end
    return r;
  endfunction

  sq_t  st  [Steps];
  sq_t  init;
  logic vld [Steps];

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.v    = in_item.sum;
    init.e20  = in_item.e20;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Steps; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Steps; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= sq_step(init);
      for (int k = 1; k < Steps; k++) st[k] <= sq_step(st[k-1]);
    end
  end

  assign out_valid     = vld[Steps-1];
  assign out_item.root = st[Steps-1].root;
  assign out_item.e20  = st[Steps-1].e20;

endmodule

// ===== rtl/core/hrpd_exp.sv =====
// Multiply chain that applies the selected exp factors to the attempt rate.
module hrpd_exp import hrpd_pkg::*; #(
  parameter int FracBits = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  exp_t        in_item,
  input  logic [31:0] attempt_rate,
  output logic        out_valid,
  output exp_t        out_item
);

  localparam int Stages = INT_BITS + FracBits;

  exp_t st  [Stages];
  exp_t src [Stages];
  exp_t nxt [Stages];
  logic vld [Stages];
  exp_t loaded;

  always_comb begin
    loaded     = in_item;
    loaded.acc = attempt_rate;
  end

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    localparam int Bit = (k < INT_BITS) ? 16 + k : 20 - k;
    logic [31:0] factor;
    logic [63:0] prod;
    if (k < INT_BITS) begin : g_int
      assign factor = INT_FACTOR[k];
    end else begin : g_frac
      assign factor = FRAC_FACTOR[k-INT_BITS];
    end
    if (k == 0) begin : g_first
      assign src[k] = loaded;
    end else begin : g_next
      assign src[k] = st[k-1];
    end
    assign prod = 64'(src[k].acc) * 64'(factor);
    always_comb begin
      nxt[k] = src[k];
      if (src[k].xb[Bit]) nxt[k].acc = prod[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Stages; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Stages; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Stages; k++) st[k] <= nxt[k];
    end
  end

  assign out_valid = vld[Stages-1];
  assign out_item  = st[Stages-1];

endmodule
